// File: design/icm_pkg.sv
package icm_pkg;

  // field widths
  localparam int S_W  = 24;            // scale, Q8.16
  localparam int Q_W  = 16;            // quaternion component, Q2.14
  localparam int P_W  = 32;            // position, Q16.16
  localparam int M_W  = 24;            // matrix entry, Q8.16
  localparam int QP_W = 2 * Q_W;       // quaternion product, Q.28
  localparam int H_W  = QP_W + 1;      // half rotation entry, Q.27
  localparam int MP_W = S_W + H_W;     // scale * half rotation, Q.43

  localparam int FRAC_S   = 16;
  localparam int ROUND_SH = 27;        // Q.43 -> Q.16
  localparam int RQ_W     = MP_W + 1 - ROUND_SH;

  localparam int IN_W   = 3 * S_W + 4 * Q_W + 3 * P_W;
  localparam int OUT_W  = 9 * M_W + 3 * P_W;
  localparam int CFG_AW = 2;

  localparam int S_LO = 0;
  localparam int Q_LO = 3 * S_W;
  localparam int P_LO = Q_LO + 4 * Q_W;

  typedef enum logic [CFG_AW-1:0] {
    CFG_USE_SCALE       = 2'd0,
    CFG_USE_ROTATION    = 2'd1,
    CFG_USE_TRANSLATION = 2'd2
  } cfg_idx_t;

  typedef logic signed [H_W-1:0] hval_t;
  typedef logic signed [S_W-1:0] scale_t;
  typedef logic signed [MP_W-1:0] mprod_t;
  typedef logic signed [M_W-1:0] mval_t;

  localparam hval_t  H_ONE = hval_t'(64'sd1 <<< ROUND_SH);   // 1.0 in Q.28, halved
  localparam scale_t S_ONE = scale_t'(64'sd1 <<< FRAC_S);

  typedef struct packed {
    logic signed [QP_W-1:0] xx, yy, zz, xy, xz, yz, xw, yw, zw;
  } qprod_t;

  typedef struct packed {
    qprod_t                    qp;
    logic [2:0][S_W-1:0]       s;
    logic [2:0][P_W-1:0]       tr;
  } st1_t;

  typedef struct packed {
    logic [2:0][2:0][H_W-1:0]  h;
    logic [2:0][S_W-1:0]       s;
    logic [2:0][P_W-1:0]       tr;
  } st2_t;

  // round half up at bit ROUND_SH, then clamp to Q8.16
  function automatic mval_t sat_round(input mprod_t p);
    logic signed [MP_W:0]   t;
    logic signed [RQ_W-1:0] q;
    mval_t                  res;
    t = $signed({p[MP_W-1], p}) + $signed((MP_W+1)'(64'sd1 <<< (ROUND_SH - 1)));
    q = t[MP_W:ROUND_SH];
    if (q[RQ_W-1:M_W-1] == '0 || q[RQ_W-1:M_W-1] == '1) begin
      res = q[M_W-1:0];
    end else if (q[RQ_W-1]) begin
      res = {1'b1, {(M_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(M_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// File: design/icm_quat.sv
module icm_quat (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     use_scale,
  input  logic                     use_translation,
  input  logic [icm_pkg::IN_W-1:0] in_data,
  output icm_pkg::st1_t            st1_r
);
  import icm_pkg::*;

  logic signed [Q_W-1:0] w, x, y, z;
  st1_t                  st1_nxt;

  assign w = in_data[Q_LO          +: Q_W];
  assign x = in_data[Q_LO + Q_W    +: Q_W];
  assign y = in_data[Q_LO + 2 * Q_W +: Q_W];
  assign z = in_data[Q_LO + 3 * Q_W +: Q_W];

  always_comb begin
    st1_nxt.qp.xx = QP_W'(x) * QP_W'(x);
    st1_nxt.qp.yy = QP_W'(y) * QP_W'(y);
    st1_nxt.qp.zz = QP_W'(z) * QP_W'(z);
    st1_nxt.qp.xy = QP_W'(x) * QP_W'(y);
    st1_nxt.qp.xz = QP_W'(x) * QP_W'(z);
    st1_nxt.qp.yz = QP_W'(y) * QP_W'(z);
    st1_nxt.qp.xw = QP_W'(x) * QP_W'(w);
    st1_nxt.qp.yw = QP_W'(y) * QP_W'(w);
    st1_nxt.qp.zw = QP_W'(z) * QP_W'(w);
    for (int i = 0; i < 3; i++) begin
      st1_nxt.s[i]  = use_scale ? in_data[S_LO + i * S_W +: S_W] : S_ONE;
      st1_nxt.tr[i] = use_translation ? in_data[P_LO + i * P_W +: P_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= st1_nxt;
    end
  end

endmodule

// File: design/icm_rot.sv
module icm_rot (
  input  logic           clk,
  input  logic           en,
  input  logic           use_rotation,
  input  icm_pkg::st1_t  st1,
  output icm_pkg::st2_t  st2_r
);
  import icm_pkg::*;

  st2_t  st2_nxt;
  hval_t xx, yy, zz, xy, xz, yz, xw, yw, zw;

  assign xx = hval_t'(st1.qp.xx);
  assign yy = hval_t'(st1.qp.yy);
  assign zz = hval_t'(st1.qp.zz);
  assign xy = hval_t'(st1.qp.xy);
  assign xz = hval_t'(st1.qp.xz);
  assign yz = hval_t'(st1.qp.yz);
  assign xw = hval_t'(st1.qp.xw);
  assign yw = hval_t'(st1.qp.yw);
  assign zw = hval_t'(st1.qp.zw);

  // entries are kept halved; the factor two folds into the final rounding shift
  always_comb begin
    st2_nxt.s  = st1.s;
    st2_nxt.tr = st1.tr;
    if (use_rotation) begin
      st2_nxt.h[0][0] = H_ONE - (yy + zz);
      st2_nxt.h[0][1] = xy + zw;
      st2_nxt.h[0][2] = xz - yw;
      st2_nxt.h[1][0] = xy - zw;
      st2_nxt.h[1][1] = H_ONE - (xx + zz);
      st2_nxt.h[1][2] = yz + xw;
      st2_nxt.h[2][0] = xz + yw;
      st2_nxt.h[2][1] = yz - xw;
      st2_nxt.h[2][2] = H_ONE - (xx + yy);
    end else begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          st2_nxt.h[i][j] = (i == j) ? H_ONE : '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_r <= st2_nxt;
    end
  end

endmodule

// File: design/icm_mul.sv
module icm_mul (
  input  logic                            clk,
  input  logic                            en_mul,
  input  logic                            en_out,
  input  icm_pkg::st2_t                   st2,
  output logic [2:0][2:0][icm_pkg::M_W-1:0] m_r,
  output logic [2:0][icm_pkg::P_W-1:0]      tr_r
);
  import icm_pkg::*;

  logic [2:0][2:0][MP_W-1:0] p_r, p_nxt;
  logic [2:0][P_W-1:0]       tr_mul_r;
  logic [2:0][2:0][M_W-1:0]  m_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p_nxt[i][j] = MP_W'($signed(st2.s[i])) * MP_W'($signed(st2.h[i][j]));
        m_nxt[i][j] = sat_round(p_r[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      p_r      <= p_nxt;
      tr_mul_r <= st2.tr;
    end
    if (en_out) begin
      m_r  <= m_nxt;
      tr_r <= tr_mul_r;
    end
  end

endmodule

// File: design/instance_transform_compose.sv
// Instance transform composer: turns scale, quaternion and position into the
// upper 3x3 and translation row of the instance matrix (row-vector form).
// Four register stages: quaternion products, rotation sums, scale multiply,
// round/saturate into the output register. out_tvalid rises when a transaction
// has reached the output register. One transaction per cycle is sustained while
// the sink is ready because every stage is fully pipelined. Back-pressure stalls
// only the occupied stages, empty stages keep filling. cfg_* writes take effect
// on the next accepted transaction (use_rotation: on the next one entering the
// rotation stage) and are meant for when the pipe is empty.
module instance_transform_compose (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [icm_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic                        cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // scale_x, scale_y, scale_z, quat_w, quat_x, quat_y, quat_z, pos_x, pos_y, pos_z
  input  logic [icm_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, tr_x, tr_y, tr_z
  output logic [icm_pkg::OUT_W-1:0]   out_tdata
);
  import icm_pkg::*;

  logic use_scale_r, use_rotation_r, use_translation_r;
  logic [3:0] v_r;
  logic [3:0] en;

  st1_t                     st1;
  st2_t                     st2;
  logic [2:0][2:0][M_W-1:0] m;
  logic [2:0][P_W-1:0]      tr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_scale_r       <= 1'b0;
      use_rotation_r    <= 1'b0;
      use_translation_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_USE_SCALE:       use_scale_r       <= cfg_wdata;
        CFG_USE_ROTATION:    use_rotation_r    <= cfg_wdata;
        CFG_USE_TRANSLATION: use_translation_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    en[3] = !v_r[3] || out_tready;
    en[2] = !v_r[2] || en[3];
    en[1] = !v_r[1] || en[2];
    en[0] = !v_r[0] || en[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      if (en[1]) v_r[1] <= v_r[0];
      if (en[2]) v_r[2] <= v_r[1];
      if (en[3]) v_r[3] <= v_r[2];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = v_r[3];
  assign out_tdata  = {tr, m};

  icm_quat u_quat (
    .clk             (clk),
    .en              (en[0]),
    .use_scale       (use_scale_r),
    .use_translation (use_translation_r),
    .in_data         (in_tdata),
    .st1_r           (st1)
  );

  icm_rot u_rot (
    .clk          (clk),
    .en           (en[1]),
    .use_rotation (use_rotation_r),
    .st1          (st1),
    .st2_r        (st2)
  );

  icm_mul u_mul (
    .clk    (clk),
    .en_mul (en[2]),
    .en_out (en[3]),
    .st2    (st2),
    .m_r    (m),
    .tr_r   (tr)
  );

endmodule

// File: design/icm_checker.sv
module icm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [icm_pkg::OUT_W-1:0] out_tdata
);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a held result keeps its data
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  // input only stalls when the output register is full and blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

  // with the sink ready throughout, an accepted transaction reaches the output
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_tvalid && in_tready, 3) && $past(rst_n, 3) && $past(rst_n, 2) &&
    $past(rst_n, 1) && $past(out_tready, 2) && $past(out_tready, 1) && out_tready
    |=> out_tvalid)
    else $error("transaction lost in the pipeline");

endmodule

bind instance_transform_compose icm_checker u_icm_checker (.*);

// File: test/tb_instance_transform_compose.sv
`timescale 1ns / 100ps

module tb_instance_transform_compose;
  import icm_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int PIPE_FLUSH = 8;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 96;
  localparam logic [CFG_AW-1:0] CFG_UNMAPPED = 2'd3;

  // fields from the lowest bit up: scale_x..z, quat_w..z, pos_x..z
  typedef struct packed {
    logic [2:0][P_W-1:0] pos;
    logic [Q_W-1:0]      qz, qy, qx, qw;
    logic [2:0][S_W-1:0] scale;
  } instance_t;

  // fields from the lowest bit up: m00..m22, tr_x..z
  typedef struct packed {
    logic [2:0][P_W-1:0]   tr;
    logic [8:0][M_W-1:0]   m;
  } xform_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic cfg_wdata = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  instance_t instance_q[$];
  xform_t    xform_q[$];
  bit flag_scale, flag_rot, flag_trans;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int err_count = 0;
  int idle_cycles = 0;

  instance_transform_compose dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // s (Q8.16) times r (Q.28), round half up to Q8.16, clamp
  function automatic logic [M_W-1:0] scaled_entry(input longint s, input longint r);
    longint q;
    q = (s * r + (64'sd1 <<< 27)) >>> 28;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q[M_W-1:0];
  endfunction

  function automatic xform_t compose_xform(input instance_t it);
    xform_t res;
    longint s[3];
    longint r[3][3];
    longint w, x, y, z;
    for (int i = 0; i < 3; i++) begin
      s[i] = flag_scale ? longint'($signed(it.scale[i])) : 64'sd65536;
    end
    if (flag_rot) begin
      w = longint'($signed(it.qw));
      x = longint'($signed(it.qx));
      y = longint'($signed(it.qy));
      z = longint'($signed(it.qz));
      r[0][0] = (64'sd1 <<< 28) - 2 * (y * y + z * z);
      r[0][1] = 2 * (x * y + z * w);
      r[0][2] = 2 * (x * z - y * w);
      r[1][0] = 2 * (x * y - z * w);
      r[1][1] = (64'sd1 <<< 28) - 2 * (x * x + z * z);
      r[1][2] = 2 * (y * z + x * w);
      r[2][0] = 2 * (x * z + y * w);
      r[2][1] = 2 * (y * z - x * w);
      r[2][2] = (64'sd1 <<< 28) - 2 * (x * x + y * y);
    end else begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          r[i][j] = (i == j) ? (64'sd1 <<< 28) : 64'sd0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        res.m[i * 3 + j] = scaled_entry(s[i], r[i][j]);
    for (int i = 0; i < 3; i++)
      res.tr[i] = flag_trans ? it.pos[i] : '0;
    return res;
  endfunction

  function automatic instance_t mk_instance(
      input logic [S_W-1:0] sx, sy, sz,
      input logic [Q_W-1:0] qw, qx, qy, qz,
      input logic [P_W-1:0] px, py, pz);
    instance_t it;
    it.scale[0] = sx; it.scale[1] = sy; it.scale[2] = sz;
    it.qw = qw; it.qx = qx; it.qy = qy; it.qz = qz;
    it.pos[0] = px; it.pos[1] = py; it.pos[2] = pz;
    return it;
  endfunction

  function automatic instance_t random_instance();
    instance_t it;
    int mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      // mostly modest scales, some over the whole range
      if (mode == 0) it.scale[i] = S_W'($urandom);
      else it.scale[i] = S_W'($urandom_range(524288) - 262144);
      it.pos[i] = $urandom;
    end
    if (mode >= 2) begin
      // components within +-10000 (about 0.61 in Q2.14) keep the entries mostly in range
      it.qw = Q_W'($urandom_range(20000) - 10000);
      it.qx = Q_W'($urandom_range(20000) - 10000);
      it.qy = Q_W'($urandom_range(20000) - 10000);
      it.qz = Q_W'($urandom_range(20000) - 10000);
    end else begin
      it.qw = Q_W'($urandom); it.qx = Q_W'($urandom);
      it.qy = Q_W'($urandom); it.qz = Q_W'($urandom);
    end
    return it;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (instance_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= instance_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    xform_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (xform_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          err_count++;
        end else begin
          want = xform_q.pop_front();
          for (int i = 0; i < 9; i++) begin
            if (got.m[i] !== want.m[i]) begin
              $error("m%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                     $signed(want.m[i]), $signed(got.m[i]));
              err_count++;
            end
          end
          for (int i = 0; i < 3; i++) begin
            if (got.tr[i] !== want.tr[i]) begin
              $error("tr_%s: expected %0d, got %0d", (i == 0) ? "x" : (i == 1) ? "y" : "z",
                     $signed(want.tr[i]), $signed(got.tr[i]));
              err_count++;
            end
          end
        end
      end
      if (in_tvalid && in_tready) xform_q.push_back(compose_xform(in_tdata));
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_USE_SCALE:       flag_scale = val;
      CFG_USE_ROTATION:    flag_rot   = val;
      CFG_USE_TRANSLATION: flag_trans = val;
      default: ;
    endcase
  endtask

  task automatic set_flags(input bit sc, input bit rot, input bit trans);
    write_reg(CFG_USE_SCALE, sc);
    write_reg(CFG_USE_ROTATION, rot);
    write_reg(CFG_USE_TRANSLATION, trans);
    // unmapped index must leave the flags alone
    write_reg(CFG_UNMAPPED, ~sc);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (instance_q.size() > 0 || in_tvalid || xform_q.size() > 0) @(negedge clk);
    repeat (PIPE_FLUSH) @(negedge clk);
  endtask

  initial begin
    int combo;
    flag_scale = 1'b0;
    flag_rot   = 1'b0;
    flag_trans = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: identity scale, rotation, zero translation
    instance_q.push_back(random_instance());
    instance_q.push_back(mk_instance('1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
    drain();

    set_flags(1'b1, 1'b1, 1'b1);
    instance_q.push_back(mk_instance('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
    instance_q.push_back(mk_instance(24'h010000, 24'h010000, 24'h010000, 16'h4000, 0, 0, 0,
                                     32'h00018000, 32'hFFFF0000, 32'h7FFFFFFF));
    instance_q.push_back(mk_instance(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF,
                                     16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF));
    instance_q.push_back(mk_instance(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000,
                                     16'h8000, 16'h8000, 32'h80000000, 32'h80000000,
                                     32'h80000000));
    instance_q.push_back(mk_instance(24'h7FFFFF, 24'h800000, 24'h000001, 16'h8000, 0, 0, 0,
                                     0, 0, 0));
    // large unnormalized quaternion, diagonal saturates
    instance_q.push_back(mk_instance(24'h7FFFFF, 24'h800000, 24'h040000, 0, 16'h7FFF, 0, 0,
                                     1, 2, 3));
    instance_q.push_back(mk_instance(24'h010000, 24'h010000, 24'h010000, 0, 0, 16'h8000,
                                     16'h7FFF, 0, 0, 0));
    // half-LSB products: rounding ties both signs
    instance_q.push_back(mk_instance(24'h000001, 24'hFFFFFF, 24'h000003, 0, 16'h2000,
                                     16'h2000, 0, 0, 0, 0));
    instance_q.push_back(mk_instance(24'hFFFFFF, 24'h000001, 24'hFFFFFD, 0, 16'h2000,
                                     16'hE000, 0, 0, 0, 0));
    // quarter turns about z and y
    instance_q.push_back(mk_instance(24'h010000, 24'h010000, 24'h010000, 16'h2D41, 0, 0,
                                     16'h2D41, 32'h00010000, 32'h00020000, 32'h00030000));
    instance_q.push_back(mk_instance(24'hFF0000, 24'h020000, 24'h800000, 16'h2D41, 0,
                                     16'h2D41, 0, 32'hFFFFFFFF, 0, 32'h80000000));
    instance_q.push_back(mk_instance(24'h555555, 24'hAAAAAA, 24'h555555, 16'h5555, 16'hAAAA,
                                     16'h5555, 16'hAAAA, 32'h55555555, 32'hAAAAAAAA,
                                     32'h55555555));
    instance_q.push_back(mk_instance(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 16'hAAAA, 16'h5555,
                                     16'hAAAA, 16'h5555, 32'hAAAAAAAA, 32'h55555555,
                                     32'hAAAAAAAA));
    instance_q.push_back(mk_instance(24'h000000, 24'h7FFFFF, 24'h000000, 16'h4000, 16'h4000,
                                     16'h4000, 16'h4000, 0, 0, 0));
    drain();

    set_flags(1'b1, 1'b0, 1'b0);
    instance_q.push_back(mk_instance(24'h7FFFFF, 24'h800000, 24'h000001, 16'h7FFF, 16'h7FFF,
                                     16'h7FFF, 16'h7FFF, 32'h12345678, 0, 0));
    drain();
    set_flags(1'b0, 1'b1, 1'b1);
    instance_q.push_back(mk_instance(24'h7FFFFF, 24'h800000, 24'h000001, 16'h7FFF, 16'h7FFF,
                                     16'h8000, 16'h7FFF, 32'h12345678, 32'h80000000, 1));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      combo = (ph < 8) ? ph : 7;
      set_flags(combo[0], combo[1], combo[2]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        instance_q.push_back(random_instance());
        // sender holds off until every pending result is back
        if (ph == 9 && n == PHASE_ITEMS / 2) begin
          while (instance_q.size() > 0 || in_tvalid || xform_q.size() > 0) @(negedge clk);
        end
      end
      drain();
    end

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
design/icm_pkg.sv
design/icm_quat.sv
design/icm_rot.sv
design/icm_mul.sv
design/instance_transform_compose.sv
design/icm_checker.sv
test/tb_instance_transform_compose.sv
